// ===== rtl/lmsb_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsb_pkg: shared types and constants for the LED matrix scroll buffer
// Item layouts, action and frame codes, glyph geometry.
// ----------------------------------------------------------------------------
package lmsb_pkg;

	localparam int ROWS        = 8;
	localparam int FRAMES      = 3;
	localparam int GLYPH_WIDTH = 5;

	localparam logic [7:0] GLYPH_MASK = 8'(8'hff << (8 - GLYPH_WIDTH));

	localparam logic [2:0] ACT_SHIFT   = 3'd0;
	localparam logic [2:0] ACT_DOWN    = 3'd1;
	localparam logic [2:0] ACT_UP      = 3'd2;
	localparam logic [2:0] ACT_CLEAR   = 3'd3;
	localparam logic [2:0] ACT_DRAW    = 3'd4;
	localparam logic [2:0] ACT_REFRESH = 3'd5;

	localparam logic [1:0] FRM_MAIN  = 2'd0;
	localparam logic [1:0] FRM_UPPER = 2'd1;
	localparam logic [1:0] FRM_LOWER = 2'd2;
	localparam logic [1:0] FRM_NONE  = 2'd3;

	typedef struct packed {
		logic [2:0]             action;
		logic [1:0]             buffer_sel;
		logic [5:0]             column;
		logic [2:0]             glyph_row;
		logic [GLYPH_WIDTH-1:0] glyph_bits;
	} cmd_item_t;

	typedef struct packed {
		logic [3:0] row_opcode;
		logic [7:0] row_data;
		logic       latch;
		logic       last;
	} word_item_t;

endpackage

// ===== rtl/led_matrix_scroll_buffer.sv =====
// ----------------------------------------------------------------------------
// led_matrix_scroll_buffer: frame store and scroller for cascaded 8x8 modules
// Usage:
//   cmd channel (valid/ready) takes one action item; cmd_ready is high only
//   while the sequencer is idle. word channel (valid/ready) carries refresh
//   words from an output register; the sequencer holds while it is full.
//   cfg_we/cfg_data write module_count at any edge (write it while idle).
// Per item, n = modules in use, one store access per read or write state:
//   shift left   a read and a write per step, n+1 steps per row, 7 rows
//   shuffle      16-byte chain per module
//   clear        8 rows per module
//   draw         one read-modify-write, two when the glyph straddles into the next module
//   refresh      one word per read and write, held while the word register is full
// A refresh item gives 8*n words, rows 7 down to 0, module 0 first.
// Reset: the store is swept to zero, one byte a cycle, all 24*MAX_MODULES bytes,
// with cmd_ready low; module_count returns to 8.
// ----------------------------------------------------------------------------
module led_matrix_scroll_buffer #(
	parameter int MAX_MODULES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  lmsb_pkg::cmd_item_t    cmd,
	output logic                   word_valid,
	input  logic                   word_ready,
	output lmsb_pkg::word_item_t   word,
	input  logic                   cfg_we,
	input  logic [3:0]             cfg_data
);

	localparam int DEPTH = lmsb_pkg::FRAMES * MAX_MODULES * lmsb_pkg::ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = $clog2(MAX_MODULES + 1);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_WR
	} state_t;

	state_t                          state_q;
	logic [AW-1:0]                   init_q;
	logic [3:0]                      count_q;
	logic [2:0]                      act_q;
	logic [1:0]                      buf_q;
	logic [5:0]                      col_q;
	logic [2:0]                      grow_q;
	logic [lmsb_pkg::GLYPH_WIDTH-1:0] bits_q;
	logic [2:0]                      row_q;
	logic [MW-1:0]                   mod_q;
	logic [3:0]                      pos_q;
	logic [7:0]                      hold_q;
	logic                            second_q;
	logic                            word_valid_q;
	lmsb_pkg::word_item_t            word_q;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;

	logic [MW-1:0] n_c;
	logic [MW-1:0] n_last;
	logic          mod_last;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_wa;
	logic [AW-1:0] mem_ra;
	logic [7:0]    mem_wd;
	logic [7:0]    glyph_val;
	logic [15:0]   mask16;
	logic [15:0]   val16;
	logic [4:0]    draw_mod;
	logic          straddle;
	logic          emit;
	logic          out_free;

	function automatic logic [AW-1:0] cell_addr(input logic [1:0] b, input logic [4:0] m,
			input logic [2:0] r);
		return AW'((int'(b) * MAX_MODULES + int'(m)) * lmsb_pkg::ROWS + int'(r));
	endfunction

	// 16-byte chain: down runs upper 0..7 then main 0..7, up runs main then lower
	function automatic logic [AW-1:0] chain_addr(input logic up, input logic [3:0] idx,
			input logic [4:0] m);
		logic [1:0] b;
		if (up) begin
			b = idx[3] ? lmsb_pkg::FRM_LOWER : lmsb_pkg::FRM_MAIN;
		end else begin
			b = idx[3] ? lmsb_pkg::FRM_MAIN : lmsb_pkg::FRM_UPPER;
		end
		return cell_addr(b, m, idx[2:0]);
	endfunction

	assign n_c = (count_q == 4'd0 || int'(count_q) > MAX_MODULES) ?
		MW'(MAX_MODULES) : MW'(count_q);
	assign n_last   = n_c - MW'(1);
	assign mod_last = (mod_q == n_last);

	assign glyph_val = 8'(bits_q) << (8 - lmsb_pkg::GLYPH_WIDTH);
	assign mask16    = {lmsb_pkg::GLYPH_MASK, 8'h00} >> col_q[2:0];
	assign val16     = {glyph_val, 8'h00} >> col_q[2:0];
	assign draw_mod  = 5'(col_q[5:3]);
	assign straddle  = (mask16[7:0] != 8'h00) && ((draw_mod + 5'd1) < 5'(n_c));

	assign out_free  = !word_valid_q || word_ready;
	assign emit      = (state_q == ST_WR) && (act_q == lmsb_pkg::ACT_REFRESH) && out_free;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign word_valid = word_valid_q;
	assign word       = word_q;

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = '0;
		mem_ra = '0;
		mem_wd = 8'h00;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = init_q;
			end
			ST_RD: begin
				unique case (act_q)
					lmsb_pkg::ACT_SHIFT, lmsb_pkg::ACT_REFRESH: begin
						mem_re = (mod_q != n_c);
						mem_ra = cell_addr(lmsb_pkg::FRM_MAIN, 5'(mod_q), row_q);
					end
					lmsb_pkg::ACT_DOWN: begin
						mem_re = (pos_q != 4'hf);
						mem_ra = chain_addr(1'b0, ~pos_q - 4'd1, 5'(mod_q));
					end
					lmsb_pkg::ACT_UP: begin
						mem_re = (pos_q != 4'hf);
						mem_ra = chain_addr(1'b1, pos_q + 4'd1, 5'(mod_q));
					end
					lmsb_pkg::ACT_DRAW: begin
						mem_re = 1'b1;
						mem_ra = cell_addr(buf_q, second_q ? draw_mod + 5'd1 : draw_mod,
							grow_q);
					end
					default: begin
						mem_re = 1'b0;
					end
				endcase
			end
			ST_WR: begin
				unique case (act_q)
					lmsb_pkg::ACT_SHIFT: begin
						mem_we = (mod_q != '0);
						mem_wa = cell_addr(lmsb_pkg::FRM_MAIN, 5'(mod_q - MW'(1)), row_q);
						mem_wd = {hold_q[6:0], (mod_q != n_c) ? rd_q[7] : 1'b0};
					end
					lmsb_pkg::ACT_DOWN: begin
						mem_we = 1'b1;
						mem_wa = chain_addr(1'b0, ~pos_q, 5'(mod_q));
						mem_wd = (pos_q == 4'hf) ? 8'h00 : rd_q;
					end
					lmsb_pkg::ACT_UP: begin
						mem_we = 1'b1;
						mem_wa = chain_addr(1'b1, pos_q, 5'(mod_q));
						mem_wd = (pos_q == 4'hf) ? 8'h00 : rd_q;
					end
					lmsb_pkg::ACT_CLEAR: begin
						mem_we = 1'b1;
						mem_wa = cell_addr(buf_q, 5'(mod_q), row_q);
					end
					lmsb_pkg::ACT_DRAW: begin
						mem_we = 1'b1;
						if (second_q) begin
							mem_wa = cell_addr(buf_q, draw_mod + 5'd1, grow_q);
							mem_wd = (rd_q & ~mask16[7:0]) | val16[7:0];
						end else begin
							mem_wa = cell_addr(buf_q, draw_mod, grow_q);
							mem_wd = (rd_q & ~mask16[15:8]) | val16[15:8];
						end
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			init_q       <= '0;
			count_q      <= 4'd8;
			word_valid_q <= 1'b0;
			act_q        <= lmsb_pkg::ACT_SHIFT;
			row_q        <= '0;
			mod_q        <= '0;
			pos_q        <= '0;
			second_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (word_valid_q && word_ready) begin
				word_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						act_q    <= cmd.action;
						buf_q    <= cmd.buffer_sel;
						col_q    <= cmd.column;
						grow_q   <= cmd.glyph_row;
						bits_q   <= cmd.glyph_bits;
						mod_q    <= '0;
						pos_q    <= '0;
						second_q <= 1'b0;
						unique case (cmd.action)
							lmsb_pkg::ACT_SHIFT: begin
								row_q   <= 3'd1;
								state_q <= ST_RD;
							end
							lmsb_pkg::ACT_DOWN, lmsb_pkg::ACT_UP: begin
								state_q <= ST_RD;
							end
							lmsb_pkg::ACT_CLEAR: begin
								row_q <= 3'd0;
								if (cmd.buffer_sel != lmsb_pkg::FRM_NONE) begin
									state_q <= ST_WR;
								end
							end
							lmsb_pkg::ACT_DRAW: begin
								if (cmd.buffer_sel != lmsb_pkg::FRM_NONE &&
										5'(cmd.column[5:3]) < 5'(n_c)) begin
									state_q <= ST_RD;
								end
							end
							lmsb_pkg::ACT_REFRESH: begin
								row_q   <= 3'd7;
								state_q <= ST_RD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					unique case (act_q)
						lmsb_pkg::ACT_SHIFT: begin
							hold_q  <= rd_q;
							state_q <= ST_RD;
							if (mod_q == n_c) begin
								mod_q <= '0;
								row_q <= row_q + 3'd1;
								if (row_q == 3'd7) begin
									state_q <= ST_IDLE;
								end
							end else begin
								mod_q <= mod_q + MW'(1);
							end
						end
						lmsb_pkg::ACT_DOWN, lmsb_pkg::ACT_UP: begin
							state_q <= ST_RD;
							pos_q   <= pos_q + 4'd1;
							if (pos_q == 4'hf) begin
								mod_q <= mod_q + MW'(1);
								if (mod_last) begin
									state_q <= ST_IDLE;
								end
							end
						end
						lmsb_pkg::ACT_CLEAR: begin
							row_q <= row_q + 3'd1;
							if (row_q == 3'd7) begin
								mod_q <= mod_q + MW'(1);
								if (mod_last) begin
									state_q <= ST_IDLE;
								end
							end
						end
						lmsb_pkg::ACT_DRAW: begin
							if (!second_q && straddle) begin
								second_q <= 1'b1;
								state_q  <= ST_RD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						lmsb_pkg::ACT_REFRESH: begin
							if (emit) begin
								word_valid_q      <= 1'b1;
								word_q.row_opcode <= 4'(row_q) + 4'd1;
								word_q.row_data   <= rd_q;
								word_q.latch      <= mod_last;
								word_q.last       <= mod_last && (row_q == 3'd0);
								state_q           <= ST_RD;
								if (mod_last) begin
									mod_q <= '0;
									row_q <= row_q - 3'd1;
									if (row_q == 3'd0) begin
										state_q <= ST_IDLE;
									end
								end else begin
									mod_q <= mod_q + MW'(1);
								end
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
